// ----- design/dmri_pkg.sv -----
// Shared types and codes for the direct-mapped record index.
// Used by dmri_hash, direct_mapped_record_index_core and dmri_checker.
`default_nettype none

package dmri_pkg;

  localparam int KEY_W    = 16;
  localparam int TYPE_W   = 8;
  localparam int CAP_W    = 16;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 7;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELETED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DEL_ABSENT = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [TYPE_W-1:0] type_code;
    logic [CAP_W-1:0]  capacity;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    found_key;
    logic [TYPE_W-1:0]   found_type;
    logic [CAP_W-1:0]    found_capacity;
  } rsp_t;

endpackage

`default_nettype wire

// ----- design/dmri_hash.sv -----
// Key mod SLOTS unit: reciprocal multiply for the quotient, then a back-subtract.
// Depends on dmri_pkg for the key width.
`default_nettype none

module dmri_hash #(
  parameter int SLOTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [dmri_pkg::KEY_W-1:0]    key,
  output logic                               done,
  output logic [$clog2(SLOTS)-1:0]           slot
);

  localparam int SW  = $clog2(SLOTS);
  localparam int KW  = dmri_pkg::KEY_W;
  localparam int SH  = KW + SW;
  localparam int MW  = KW + 1;
  localparam int PRW = KW + MW;
  // ceil(2^SH / SLOTS): the shifted product is the exact quotient for every key
  localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + SLOTS - 1) / SLOTS);

  logic           busy;
  logic           calc;
  logic [KW-1:0]  kreg;
  logic [PRW-1:0] prod;
  logic [KW-1:0]  quot;
  logic [KW-1:0]  back;

  always_comb begin
    prod = PRW'(kreg) * PRW'(RECIP);
    back = quot * KW'(SLOTS);
  end

  // start -> quotient -> remainder, done with the remainder in place
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      calc <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      calc <= busy;
      done <= calc;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kreg <= key;
    end
    if (busy) begin
      quot <= KW'(prod >> SH);
    end
    if (calc) begin
      slot <= SW'(kreg - back);
    end
  end

endmodule

`default_nettype wire

// ----- design/direct_mapped_record_index_core.sv -----
// Direct-mapped record index: record store, slot table and operation sequencer.
// Depends on dmri_pkg and dmri_hash.
//
// One operation at a time. Each beat first runs the key through the mod unit
// (reciprocal multiply, then back-subtract), after which an add writes and
// answers, while a search or a delete reads the slot table, then the record,
// and checks its key. A delete that hits adds the move of the last record and
// a rebuild of the slot table that reads every remaining record through the
// single store read port, one per cycle.
// req_ready is high only while the sequencer is idle, from the cycle after the
// result is loaded; a finished result sits in the output register and does
// not hold up the next request, but the next result waits until it is taken.
// The slot table's valid bits clear at reset, so no clearing pass is needed;
// unwritten record store entries may be read, but their data is not used.
`default_nettype none

module direct_mapped_record_index_core #(
  parameter int SLOTS   = 16,
  parameter int RECORDS = 128
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire dmri_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output dmri_pkg::rsp_t       rsp
);

  localparam int SW = $clog2(SLOTS);
  localparam int PW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int CW = $clog2(RECORDS + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_HASH    = 4'd1;
  localparam logic [3:0] S_REC_RD  = 4'd2;
  localparam logic [3:0] S_CHECK   = 4'd3;
  localparam logic [3:0] S_MOVE    = 4'd4;
  localparam logic [3:0] S_REBUILD = 4'd5;
  localparam logic [3:0] S_DONE    = 4'd6;

  typedef struct packed {
    logic [dmri_pkg::KEY_W-1:0]  key;
    logic [dmri_pkg::TYPE_W-1:0] type_code;
    logic [dmri_pkg::CAP_W-1:0]  capacity;
    logic [SW-1:0]               slot;
  } rec_t;

  logic [3:0]           state;
  dmri_pkg::req_t       op;
  dmri_pkg::rsp_t       res;
  logic [CW-1:0]        count;
  logic [CW-1:0]        last_idx;
  logic                 full;
  logic [SLOTS-1:0]     slot_valid;
  logic [PW-1:0]        slot_mem [SLOTS];
  logic [PW-1:0]        slot_rd;
  logic                 slot_hit;
  rec_t                 rec_mem [RECORDS];
  rec_t                 rec_rd;
  logic [PW-1:0]        hole;
  logic                 lookup_ok;
  logic                 match;
  logic [CW-1:0]        rb_idx;
  logic                 rb_pend;
  logic [PW-1:0]        rb_wpos;

  logic                 hash_start;
  logic                 hash_done;
  logic [SW-1:0]        hash_slot;

  logic                 rec_we;
  logic [PW-1:0]        rec_wa;
  rec_t                 rec_wd;
  logic                 rec_re;
  logic [PW-1:0]        rec_ra;
  logic                 slot_we;
  logic [SW-1:0]        slot_wa;
  logic [PW-1:0]        slot_wd;
  logic                 rsp_load;

  function automatic dmri_pkg::rsp_t make_rsp(
    input logic [dmri_pkg::STATUS_W-1:0] st,
    input logic [dmri_pkg::POS_W-1:0]    pos,
    input logic [dmri_pkg::KEY_W-1:0]    fkey,
    input logic [dmri_pkg::TYPE_W-1:0]   ftype,
    input logic [dmri_pkg::CAP_W-1:0]    fcap
  );
    return '{status: st, position: pos, found_key: fkey, found_type: ftype,
             found_capacity: fcap};
  endfunction

  assign req_ready  = (state == S_IDLE);
  assign hash_start = req_valid && req_ready;
  assign last_idx   = count - CW'(1);
  assign full       = count >= CW'(RECORDS);
  assign match      = lookup_ok && (rec_rd.key == op.key);
  assign rsp_load   = (state == S_DONE) && (!rsp_valid || rsp_ready);

  dmri_hash #(
    .SLOTS(SLOTS)
  ) u_hash (
    .clk  (clk),
    .rst  (rst),
    .start(hash_start),
    .key  (req.key),
    .done (hash_done),
    .slot (hash_slot)
  );

  // memory port control
  always_comb begin
    rec_we  = 1'b0;
    rec_wa  = '0;
    rec_wd  = '0;
    rec_re  = 1'b0;
    rec_ra  = '0;
    slot_we = 1'b0;
    slot_wa = '0;
    slot_wd = '0;
    unique case (state)
      S_HASH: begin
        if (hash_done && op.kind == dmri_pkg::KIND_ADD && !full) begin
          rec_we  = 1'b1;
          rec_wa  = count[PW-1:0];
          rec_wd  = '{key: op.key, type_code: op.type_code,
                      capacity: op.capacity, slot: hash_slot};
          slot_we = 1'b1;
          slot_wa = hash_slot;
          slot_wd = count[PW-1:0];
        end
      end
      S_REC_RD: begin
        rec_re = 1'b1;
        rec_ra = slot_rd;
      end
      S_CHECK: begin
        // fetch the last record in case this is a delete that hits
        rec_re = 1'b1;
        rec_ra = last_idx[PW-1:0];
      end
      S_MOVE: begin
        rec_we = 1'b1;
        rec_wa = hole;
        rec_wd = rec_rd;
      end
      S_REBUILD: begin
        rec_re  = rb_idx < count;
        rec_ra  = rb_idx[PW-1:0];
        slot_we = rb_pend;
        slot_wa = rec_rd.slot;
        slot_wd = rb_wpos;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    if (rec_re) begin
      rec_rd <= rec_mem[rec_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (state == S_HASH) begin
      slot_rd <= slot_mem[hash_slot];
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      slot_valid <= '0;
      rsp_valid  <= 1'b0;
      rb_pend    <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            if (op.kind == dmri_pkg::KIND_ADD) begin
              if (!full) begin
                count                 <= count + CW'(1);
                slot_valid[hash_slot] <= 1'b1;
              end
              state <= S_DONE;
            end else if (op.kind == dmri_pkg::KIND_SEARCH ||
                         op.kind == dmri_pkg::KIND_DELETE) begin
              state <= S_REC_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_REC_RD: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (op.kind == dmri_pkg::KIND_DELETE && match) begin
            state <= S_MOVE;
          end else begin
            state <= S_DONE;
          end
        end
        S_MOVE: begin
          count      <= last_idx;
          slot_valid <= '0;
          rb_pend    <= 1'b0;
          state      <= S_REBUILD;
        end
        S_REBUILD: begin
          rb_pend <= rec_re;
          if (rb_pend) begin
            slot_valid[rec_rd.slot] <= 1'b1;
          end
          if (!rec_re && !rb_pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (hash_start) begin
      op <= req;
    end
    if (state == S_HASH) begin
      slot_hit <= slot_valid[hash_slot];
      if (hash_done) begin
        if (op.kind != dmri_pkg::KIND_ADD) begin
          res <= make_rsp(dmri_pkg::ST_NOT_FOUND, '0, '0, '0, '0);
        end else if (full) begin
          res <= make_rsp(dmri_pkg::ST_FULL, '0, '0, '0, '0);
        end else begin
          res <= make_rsp(dmri_pkg::ST_ADDED, dmri_pkg::POS_W'(count), '0, '0, '0);
        end
      end
    end
    if (state == S_REC_RD) begin
      hole      <= slot_rd;
      lookup_ok <= slot_hit && (CW'(slot_rd) < count);
    end
    if (state == S_CHECK) begin
      if (op.kind == dmri_pkg::KIND_SEARCH && match) begin
        res <= make_rsp(dmri_pkg::ST_FOUND, dmri_pkg::POS_W'(hole), rec_rd.key,
                        rec_rd.type_code, rec_rd.capacity);
      end else if (op.kind == dmri_pkg::KIND_SEARCH) begin
        res <= make_rsp(dmri_pkg::ST_NOT_FOUND, '0, '0, '0, '0);
      end else if (match) begin
        res <= make_rsp(dmri_pkg::ST_DELETED, '0, '0, '0, '0);
      end else begin
        res <= make_rsp(dmri_pkg::ST_DEL_ABSENT, '0, '0, '0, '0);
      end
    end
    if (state == S_MOVE) begin
      rb_idx <= '0;
    end
    if (state == S_REBUILD && rec_re) begin
      rb_idx  <= rb_idx + CW'(1);
      rb_wpos <= rb_idx[PW-1:0];
    end
    if (rsp_load) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

// ----- design/dmri_checker.sv -----
// Port-level checks for direct_mapped_record_index_core, attached by bind.
// Depends on dmri_pkg.
`default_nettype none

module dmri_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_valid,
  input wire logic            req_ready,
  input wire dmri_pkg::req_t  req,
  input wire logic            rsp_valid,
  input wire logic            rsp_ready,
  input wire dmri_pkg::rsp_t  rsp
);

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // an accepted request keeps the block busy for at least the hash
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready ##1 !req_ready)
    else $error("request accepted while busy");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= dmri_pkg::ST_DEL_ABSENT)
    else $error("status code out of range");

  // only found results carry record data
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != dmri_pkg::ST_FOUND |->
      rsp.found_key == '0 && rsp.found_type == '0 && rsp.found_capacity == '0)
    else $error("record data on a result that found nothing");

  // deletes, misses and full adds report position zero
  a_zero_position: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == dmri_pkg::ST_FULL ||
                  rsp.status == dmri_pkg::ST_NOT_FOUND ||
                  rsp.status == dmri_pkg::ST_DELETED ||
                  rsp.status == dmri_pkg::ST_DEL_ABSENT) |->
      rsp.position == '0)
    else $error("nonzero position on a result without one");

endmodule

bind direct_mapped_record_index_core dmri_checker u_dmri_checker (.*);

`default_nettype wire
